// ----- src/positional_ordered_list_defines.svh -----
// ---------------------------------------------------------------------------
// positional_ordered_list_defines
// assertion macros of the list checker
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_ORDERED_LIST_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define POL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pol check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define POL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pol check failed");

`endif

// ----- src/pol_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pol_pkg
// shared widths, action codes and status codes of the ordered list
// ---------------------------------------------------------------------------
package pol_pkg;

  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 3;

  // action code seven is unused and ignored
  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_INS_POS   = 3'd2,
    ACT_DEL_FRONT = 3'd3,
    ACT_DEL_BACK  = 3'd4,
    ACT_DEL_POS   = 3'd5,
    ACT_DISPLAY   = 3'd6
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_BADPOS = 3'd1,
    ST_RANGE  = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

endpackage

// ----- src/pol_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pol_ram
// entry memory: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
module pol_ram #(
  parameter int DEPTH = 32,
  parameter int DW    = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/pol_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pol_ctrl
// action sequencer: decode, shift entries through the memory, result register
// ---------------------------------------------------------------------------
module pol_ctrl
  import pol_pkg::*;
#(
  parameter int CAPACITY = 32,
  parameter int DW       = 32,
  parameter int AW       = 5,
  parameter int CW       = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic [POS_W-1:0]    in_position,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [VALUE_W-1:0]  out_data,
  output logic                out_last,
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output logic [DW-1:0]       ram_wdata,
  output logic                ram_re,
  output logic [AW-1:0]       ram_raddr,
  input  logic [DW-1:0]       ram_rdata
);

  localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_PUT,
    S_DEL_READ,
    S_DEL_SHIFT,
    S_DEL_DONE,
    S_DISP
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] end_r, end_nxt;
  logic [DW-1:0] value_r, value_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [VALUE_W-1:0]  out_data_r;
  logic                out_last_r;

  logic                emit;
  status_t             emit_status;
  logic [VALUE_W-1:0]  emit_data;
  logic                emit_last;

  logic                  out_free;
  logic                  accept;
  logic [CMP_W-1:0]      cnt_c, pos_c, idx_c;
  logic                  full, empty, pos_zero;
  logic [AW-1:0]         ins_idx, del_idx, pos_m1;
  logic signed [VALUE_W-1:0] value_s;
  logic signed [DW-1:0]  stored_s;
  logic signed [DW-1:0]  rdata_s, held_s;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  assign cnt_c    = CMP_W'(count_r);
  assign pos_c    = CMP_W'(in_position);
  assign idx_c    = CMP_W'(idx_r);
  assign full     = cnt_c >= CMP_W'(CAPACITY);
  assign empty    = (count_r == '0);
  assign pos_zero = (in_position == '0);
  assign pos_m1   = AW'(in_position - POS_W'(1));

  // stored values keep the low DW bits, read back sign-extended
  assign value_s  = in_value;
  assign stored_s = DW'(value_s);
  assign rdata_s  = ram_rdata;
  assign held_s   = value_r;

  always_comb begin
    case (action_t'(in_action))
      ACT_INS_FRONT: ins_idx = '0;
      ACT_INS_BACK:  ins_idx = AW'(count_r);
      default:       ins_idx = pos_m1;
    endcase
    case (action_t'(in_action))
      ACT_DEL_FRONT: del_idx = '0;
      ACT_DEL_BACK:  del_idx = AW'(count_r - CW'(1));
      default:       del_idx = pos_m1;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    end_nxt     = end_r;
    value_nxt   = value_r;
    ram_we      = 1'b0;
    ram_waddr   = idx_r;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = idx_r;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_data   = '0;
    emit_last   = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (action_t'(in_action))
            ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS: begin
              if (full) begin
                emit        = 1'b1;
                emit_status = ST_FULL;
              end else if (action_t'(in_action) == ACT_INS_POS && pos_zero) begin
                emit        = 1'b1;
                emit_status = ST_BADPOS;
              end else if (action_t'(in_action) == ACT_INS_POS &&
                           pos_c > cnt_c + CMP_W'(1)) begin
                emit        = 1'b1;
                emit_status = ST_RANGE;
              end else if (CMP_W'(ins_idx) == cnt_c) begin
                // append: nothing to move
                ram_we    = 1'b1;
                ram_waddr = ins_idx;
                ram_wdata = stored_s;
                count_nxt = count_r + CW'(1);
                emit      = 1'b1;
              end else begin
                value_nxt = stored_s;
                end_nxt   = ins_idx;
                idx_nxt   = AW'(count_r);
                ram_re    = 1'b1;
                ram_raddr = AW'(count_r - CW'(1));
                state_nxt = S_INS_SHIFT;
              end
            end
            ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_POS: begin
              if (empty) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end else if (action_t'(in_action) == ACT_DEL_POS && pos_zero) begin
                emit        = 1'b1;
                emit_status = ST_BADPOS;
              end else if (action_t'(in_action) == ACT_DEL_POS && pos_c > cnt_c) begin
                emit        = 1'b1;
                emit_status = ST_RANGE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = del_idx;
                idx_nxt   = del_idx;
                state_nxt = S_DEL_READ;
              end
            end
            ACT_DISPLAY: begin
              if (empty) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                idx_nxt   = '0;
                state_nxt = S_DISP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // move entry idx-1 up to idx, walking down toward the insert slot
      S_INS_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        if (idx_r - AW'(1) != end_r) begin
          ram_re    = 1'b1;
          ram_raddr = idx_r - AW'(2);
          idx_nxt   = idx_r - AW'(1);
        end else begin
          state_nxt = S_INS_PUT;
        end
      end

      S_INS_PUT: begin
        if (out_free) begin
          ram_we    = 1'b1;
          ram_waddr = end_r;
          ram_wdata = value_r;
          count_nxt = count_r + CW'(1);
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_DEL_READ: begin
        value_nxt = ram_rdata;
        if (idx_c + CMP_W'(1) < cnt_c) begin
          ram_re    = 1'b1;
          ram_raddr = idx_r + AW'(1);
          state_nxt = S_DEL_SHIFT;
        end else begin
          state_nxt = S_DEL_DONE;
        end
      end

      // move entry idx+1 down to idx, walking toward the tail
      S_DEL_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        if (idx_c + CMP_W'(2) < cnt_c) begin
          ram_re    = 1'b1;
          ram_raddr = idx_r + AW'(2);
          idx_nxt   = idx_r + AW'(1);
        end else begin
          state_nxt = S_DEL_DONE;
        end
      end

      S_DEL_DONE: begin
        if (out_free) begin
          count_nxt = count_r - CW'(1);
          emit      = 1'b1;
          emit_data = VALUE_W'(held_s);
          state_nxt = S_IDLE;
        end
      end

      S_DISP: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_data = VALUE_W'(rdata_s);
          emit_last = (idx_c + CMP_W'(1) == cnt_c);
          if (idx_c + CMP_W'(1) == cnt_c) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_r + AW'(1);
            idx_nxt   = idx_r + AW'(1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    idx_r   <= idx_nxt;
    end_r   <= end_nxt;
    value_r <= value_nxt;
    if (emit) begin
      out_status_r <= emit_status;
      out_data_r   <= emit_data;
      out_last_r   <= emit_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

endmodule

// ----- src/positional_ordered_list.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// positional_ordered_list
// bounded ordered list of signed values with positional insert and delete
// ---------------------------------------------------------------------------
// The list lives in one entry memory (CAPACITY words of DATA_WIDTH bits,
// one write and one read port, registered read data) next to a count
// register. An insert at the tail, and any item that ends in an error
// status, is answered straight from the idle state. An insert at 0-based
// slot k of a list of n entries moves the n-k entries above it one slot
// up, one per cycle; a delete of slot k moves the n-k-1 entries above it
// down. Display streams n beats at one per cycle while the receiver is
// ready (one empty beat for an empty list). The single write port of the
// entry memory sets the pace of the shifts. Reads and writes of a shift
// always touch different slots, so no forwarding is needed. No clearing
// pass follows reset: only slots below the count are ever read. A new
// input beat is taken only when the output register is empty or its beat
// leaves in the same cycle.
// ---------------------------------------------------------------------------
module positional_ordered_list
  import pol_pkg::*;
#(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] value, [37:32] position, [39:38] zero
  input  logic [2:0]  in_tuser,   // [2:0] action
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] data_out
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast   // last beat of this item
);

  // address and count widths follow the capacity
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // sequencer: decode, shift loops and the output register
  pol_ctrl #(
    .CAPACITY (CAPACITY),
    .DW       (DATA_WIDTH),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_action   (in_tuser),
    .in_value    (in_tdata[31:0]),
    .in_position (in_tdata[37:32]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (out_tuser),
    .out_data    (out_tdata),
    .out_last    (out_tlast),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  // entry memory, list order equals slot order
  pol_ram #(
    .DEPTH (CAPACITY),
    .DW    (DATA_WIDTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- src/pol_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pol_checker
// port-level checks of the ordered list, bound to the top level
// ---------------------------------------------------------------------------
`include "positional_ordered_list_defines.svh"

module pol_checker
  import pol_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // a stalled result beat holds
  `POL_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // error and empty beats carry zero data
  `POL_ASSERT_SAME(a_err_zero, out_tvalid && out_tuser != ST_OK, out_tdata == '0)

  // an error beat always closes its item
  `POL_ASSERT_SAME(a_err_last, out_tvalid && out_tuser != ST_OK, out_tlast)

  // no new item while a display stream is still running
  `POL_ASSERT_SAME(a_disp_block, out_tvalid && !out_tlast, !in_tready)

endmodule

bind positional_ordered_list pol_checker u_pol_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ----- tb/positional_ordered_list_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// positional_ordered_list_tb
// stream-level test of the bounded ordered list
// ---------------------------------------------------------------------------
// Drives list commands into the input stream and checks every result beat.
// A scoreboard object keeps its own copy of the list: each accepted command
// is applied to it, and the result beats that this causes are queued in
// order. Every beat taken from the result stream is compared with the oldest
// queued beat, field by field. Directed commands walk the empty, badpos and
// range statuses and edge positions; random traffic then fills the list to
// capacity and drains it under three idling patterns, one long receiver stall.
// ---------------------------------------------------------------------------
module positional_ordered_list_tb;
  import pol_pkg::*;

  localparam int CAPACITY   = 32;
  localparam int DATA_WIDTH = 32;
  // the one action code that the block ignores
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;

  typedef struct {
    status_t           status;
    logic [VALUE_W-1:0] data;
    logic              last;
  } list_beat_t;

  // -------------------------------------------------------------------------
  // scoreboard: mirror of the list plus the beats it still owes
  // -------------------------------------------------------------------------
  class list_scoreboard;
    logic [VALUE_W-1:0] mirror_entries[CAPACITY];
    int unsigned        mirror_count;
    list_beat_t         awaited_beats[$];
    int unsigned        errors;
    int unsigned        commands;
    int unsigned        beats_checked;
    int unsigned        status_hits[5];

    function new();
      mirror_count  = 0;
      errors        = 0;
      commands      = 0;
      beats_checked = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void owe(status_t st, logic [VALUE_W-1:0] d, logic last);
      list_beat_t b;
      b.status = st;
      b.data   = d;
      b.last   = last;
      awaited_beats.push_back(b);
      status_hits[st]++;
    endfunction

    function void put_entry(int unsigned idx, logic [VALUE_W-1:0] v);
      int unsigned i;
      for (i = mirror_count; i > idx; i--) mirror_entries[i] = mirror_entries[i-1];
      mirror_entries[idx] = v;
      mirror_count++;
    endfunction

    function logic [VALUE_W-1:0] take_entry(int unsigned idx);
      logic [VALUE_W-1:0] v;
      int unsigned i;
      v = mirror_entries[idx];
      for (i = idx; i + 1 < mirror_count; i++) mirror_entries[i] = mirror_entries[i+1];
      mirror_count--;
      return v;
    endfunction

    // apply one accepted command and queue what it causes
    function void apply_command(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] val,
                                logic [POS_W-1:0] pos);
      int unsigned i;
      commands++;
      case (act)
        ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS: begin
          if (mirror_count >= CAPACITY) begin
            owe(ST_FULL, '0, 1'b1);
          end else if (act == ACT_INS_FRONT) begin
            put_entry(0, val);
            owe(ST_OK, '0, 1'b1);
          end else if (act == ACT_INS_BACK) begin
            put_entry(mirror_count, val);
            owe(ST_OK, '0, 1'b1);
          end else if (pos == 0) begin
            owe(ST_BADPOS, '0, 1'b1);
          end else if (pos > mirror_count + 1) begin
            owe(ST_RANGE, '0, 1'b1);
          end else begin
            put_entry(pos - 1, val);
            owe(ST_OK, '0, 1'b1);
          end
        end
        ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_POS: begin
          if (mirror_count == 0) begin
            owe(ST_EMPTY, '0, 1'b1);
          end else if (act == ACT_DEL_FRONT) begin
            owe(ST_OK, take_entry(0), 1'b1);
          end else if (act == ACT_DEL_BACK) begin
            owe(ST_OK, take_entry(mirror_count - 1), 1'b1);
          end else if (pos == 0) begin
            owe(ST_BADPOS, '0, 1'b1);
          end else if (pos > mirror_count) begin
            owe(ST_RANGE, '0, 1'b1);
          end else begin
            owe(ST_OK, take_entry(pos - 1), 1'b1);
          end
        end
        ACT_DISPLAY: begin
          if (mirror_count == 0) begin
            owe(ST_EMPTY, '0, 1'b1);
          end else begin
            for (i = 0; i < mirror_count; i++)
              owe(ST_OK, mirror_entries[i], (i + 1 == mirror_count));
          end
        end
        default: ;  // ignored code, nothing owed
      endcase
    endfunction

    function void check_beat(logic [STATUS_W-1:0] st, logic [VALUE_W-1:0] d, logic last);
      list_beat_t b;
      beats_checked++;
      if (awaited_beats.size() == 0) begin
        $display("%0t: unexpected result beat status %0d data %h last %b", $time, st, d, last);
        errors++;
        return;
      end
      b = awaited_beats.pop_front();
      if (st !== b.status) begin
        $display("%0t: status expected %0d actual %0d", $time, b.status, st);
        errors++;
      end
      if (d !== b.data) begin
        $display("%0t: data expected %h actual %h", $time, b.data, d);
        errors++;
      end
      if (last !== b.last) begin
        $display("%0t: last expected %b actual %b", $time, b.last, last);
        errors++;
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // signals and the block
  // -------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;    // [31:0] value, [37:32] position, [39:38] zero
  logic [2:0]  in_tuser;    // [2:0] action
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // [31:0] data_out
  logic [2:0]  out_tuser;   // [2:0] status
  logic        out_tlast;

  list_scoreboard sb;

  // idle rates in percent of cycles, changed per phase
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  // long receiver stall, counted down by the receiver process
  int unsigned hold_cycles;
  // random traffic leans toward inserts while filling, deletes while draining
  bit          filling;

  positional_ordered_list #(CAPACITY, DATA_WIDTH) u_dut (
    clk, rst_n,
    in_tvalid, in_tready, in_tdata, in_tuser,
    out_tvalid, out_tready, out_tdata, out_tuser, out_tlast
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // receiver: ready changes at the falling edge only
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready = 1'b0;
        hold_cycles--;
      end else begin
        out_tready = ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // result monitor: sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tuser, out_tdata, out_tlast);
  end

  // offer one command beat and hold it until taken
  task automatic send_command(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] val,
                              logic [POS_W-1:0] pos);
    // random sender gaps ahead of the beat
    while ($urandom_range(99) < in_idle_pct) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {2'b00, pos, val};
    in_tuser  = act;
    do @(posedge clk); while (!in_tready);
    sb.apply_command(act, val, pos);
  endtask

  // one random command, shaped by how full the mirror list is
  task automatic send_random_command();
    int unsigned        r;
    int unsigned        ins_share;
    logic [ACTION_W-1:0] act;
    logic [VALUE_W-1:0]  val;
    logic [POS_W-1:0]    pos;
    bit                  is_insert;
    if (sb.mirror_count == 0) filling = 1'b1;
    if (sb.mirror_count == CAPACITY && $urandom_range(3) == 0) filling = 1'b0;
    ins_share = filling ? 77 : 14;
    val = $urandom();
    // extremes of the value now and then
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: val = 32'h8000_0000;
        1: val = 32'h7fff_ffff;
        2: val = 32'h0000_0000;
        default: val = 32'hffff_ffff;
      endcase
    end
    r = $urandom_range(99);
    is_insert = 1'b0;
    if (r < 2) begin
      act = ACT_UNUSED;
    end else if (r < 9) begin
      act = ACT_DISPLAY;
    end else if (r < 9 + ins_share) begin
      act = 3'(ACT_INS_FRONT) + 3'($urandom_range(2));
      is_insert = 1'b1;
    end else begin
      act = 3'(ACT_DEL_FRONT) + 3'($urandom_range(2));
    end
    // mostly legal positions, some anywhere in the field
    if ($urandom_range(9) == 0) begin
      pos = POS_W'($urandom_range(63));
    end else if (is_insert) begin
      pos = POS_W'($urandom_range(sb.mirror_count + 1, 1));
    end else if (sb.mirror_count > 0) begin
      pos = POS_W'($urandom_range(sb.mirror_count, 1));
    end else begin
      pos = POS_W'($urandom_range(63));
    end
    send_command(act, val, pos);
  endtask

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    rst_n        = 1'b0;
    in_idle_pct  = 8;
    out_idle_pct = 46;
    hold_cycles  = 0;
    filling      = 1'b1;
    sb           = new();

    // synchronous reset, released at a falling edge
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty list first, every delete reports empty
    send_command(ACT_DISPLAY,   32'h0, 6'd0);
    send_command(ACT_DEL_FRONT, 32'h0, 6'd1);
    send_command(ACT_DEL_BACK,  32'h0, 6'd1);
    // empty wins over a bad position
    send_command(ACT_DEL_POS,   32'h0, 6'd0);
    send_command(ACT_INS_POS,   32'h1234_5678, 6'd0);
    send_command(ACT_INS_POS,   32'h1234_5678, 6'd2);
    // build a short list from the value extremes
    send_command(ACT_INS_FRONT, 32'h8000_0000, 6'd0);
    send_command(ACT_INS_BACK,  32'h7fff_ffff, 6'd63);
    send_command(ACT_INS_POS,   32'hffff_ffff, 6'd3);   // count+1
    send_command(ACT_INS_POS,   32'h0000_0000, 6'd1);
    send_command(ACT_INS_POS,   32'hdead_beef, 6'd63);  // out of range
    send_command(ACT_INS_POS,   32'h5a5a_5a5a, 6'd2);
    send_command(ACT_DISPLAY,   32'h0, 6'd0);
    // delete error cases on a non-empty list, then a legal delete
    send_command(ACT_DEL_POS,   32'h0, 6'd0);
    send_command(ACT_DEL_POS,   32'h0, 6'd6);           // count+1
    send_command(ACT_DEL_POS,   32'h0, 6'd63);
    send_command(ACT_DEL_POS,   32'h0, 6'd3);
    // unused code, must be silently dropped
    send_command(ACT_UNUSED,    32'ha5a5_a5a5, 6'd21);
    send_command(ACT_DEL_FRONT, 32'h0, 6'd0);
    send_command(ACT_DEL_BACK,  32'h0, 6'd0);
    send_command(ACT_DEL_POS,   32'h0, 6'd2);
    send_command(ACT_DISPLAY,   32'h0, 6'd0);
    send_command(ACT_DEL_POS,   32'h0, 6'd1);
    send_command(ACT_DISPLAY,   32'h0, 6'd0);

    // random phase one: sender rarely idles, receiver often
    repeat (50) send_random_command();

    // random phase two: roles swapped, opened by a long receiver stall
    in_idle_pct  = 46;
    out_idle_pct = 8;
    hold_cycles  = 300;
    repeat (50) send_random_command();

    // random phase three: full rate both ways
    in_idle_pct  = 0;
    out_idle_pct = 0;
    repeat (46) send_random_command();

    @(negedge clk);
    in_tvalid = 1'b0;

    // drain everything still owed, then a quiet tail for stray beats
    while (sb.awaited_beats.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("tb: %0d commands, %0d result beats checked, random fill and drain runs",
             sb.commands, sb.beats_checked);
    $display("tb: status counts ok %0d badpos %0d range %0d empty %0d full %0d",
             sb.status_hits[ST_OK], sb.status_hits[ST_BADPOS], sb.status_hits[ST_RANGE],
             sb.status_hits[ST_EMPTY], sb.status_hits[ST_FULL]);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
